// ===== rtl/sha512_sha384_hash_engine_macros.svh =====
// Assertion macros shared by the hash engine RTL.
// Included by the modules that carry concurrent checks.
`ifndef SHA512_SHA384_HASH_ENGINE_MACROS_SVH
`define SHA512_SHA384_HASH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sha_pkg.sv =====
// Package for the SHA-512/384 engine: round constants, initial values, types.
// Used by sha_core and the top level of the engine.
`default_nettype none
package sha_pkg;
	localparam int Rounds = 80;
	typedef logic [63:0] word_t;

	typedef struct packed {
		logic start;
		logic busy;
	} ctl_t;

	function automatic word_t round_k(input logic [6:0] i);
		word_t k;
		case (i)
			7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
			7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
			7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
			7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
			7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic word_t init_value(input logic mode, input logic [2:0] i);
		word_t v;
		case ({mode, i})
			4'd0: v = 64'h6a09e667f3bcc908; 4'd1: v = 64'hbb67ae8584caa73b;
			4'd2: v = 64'h3c6ef372fe94f82b; 4'd3: v = 64'ha54ff53a5f1d36f1;
			4'd4: v = 64'h510e527fade682d1; 4'd5: v = 64'h9b05688c2b3e6c1f;
			4'd6: v = 64'h1f83d9abfb41bd6b; 4'd7: v = 64'h5be0cd19137e2179;
			4'd8: v = 64'hcbbb9d5dc1059ed8; 4'd9: v = 64'h629a292a367cd507;
			4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
			4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
			4'd14: v = 64'hdb0c2e0d64f98fa7; default: v = 64'h47b5481dbefa4fa4;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/sha_if.sv =====
// Valid/ready channel interfaces for message input and digest output.
// Depends on nothing else.
`default_nettype none
interface sha_in_if;
	logic valid;
	logic ready;
	logic [63:0] data_word;
	logic [3:0] valid_bytes;
	logic message_end;
	modport source(output valid, data_word, valid_bytes, message_end, input ready);
	modport sink(input valid, data_word, valid_bytes, message_end, output ready);
endinterface

interface sha_out_if;
	logic valid;
	logic ready;
	logic [63:0] digest_word;
	logic digest_last;
	modport source(output valid, digest_word, digest_last, input ready);
	modport sink(input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha_core.sv =====
// Compression core: one round per cycle with a 16-entry rolling schedule.
// Depends on sha_pkg and the assertion macros header. Updates the hash words in place when the block ends.
`default_nettype none
`include "sha512_sha384_hash_engine_macros.svh"
module sha_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sha_pkg::ctl_t ctl,
	input  wire logic [63:0]   blk [16],
	input  wire logic          iv_load,
	input  wire logic          iv_mode,
	output logic [63:0]        hash [8],
	output logic               done
);
	logic [63:0] w_q [16];
	logic [63:0] v_q [8];
	logic [6:0]  rnd_q;
	logic        run_q;
	logic        fin_q;
	logic [63:0] s0, s1, wn, t1, t2, e, a, ch, maj;

	always_comb begin
		s0 = {w_q[1][0], w_q[1][63:1]} ^ {w_q[1][7:0], w_q[1][63:8]} ^ (w_q[1] >> 7);
		s1 = {w_q[14][18:0], w_q[14][63:19]} ^ {w_q[14][60:0], w_q[14][63:61]}
			^ (w_q[14] >> 6);
		wn = s1 + w_q[9] + s0 + w_q[0];
		e  = v_q[4];
		a  = v_q[0];
		ch = (e & v_q[5]) ^ (~e & v_q[6]);
		maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
			+ ch + sha_pkg::round_k(rnd_q) + w_q[0];
		t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]}) + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
			for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::init_value(1'b0, 3'(i));
		end else begin
			fin_q <= 1'b0;
			if (iv_load) begin
				for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::init_value(iv_mode, 3'(i));
			end else if (ctl.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
				for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
				for (int i = 0; i < 8; i++) v_q[i] <= hash[i];
			end else if (run_q) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wn;
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(sha_pkg::Rounds - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v_q[i];
			end
		end
	end
	assign done = fin_q;

	`SHA_ASSERT_IMP(a_rnd_range, clk, arst_n, run_q, rnd_q < 7'(sha_pkg::Rounds))
	`SHA_ASSERT_NXT(a_fin_once, clk, arst_n, fin_q, !fin_q)
	`SHA_ASSERT_IMP(a_no_start_busy, clk, arst_n, ctl.start, !run_q && !fin_q)
endmodule
`default_nettype wire

// ===== rtl/sha512_sha384_hash_engine.sv =====
// Top level of the SHA-512/384 engine: byte packing, padding and digest output.
// Depends on sha_pkg, sha_if and sha_core.
//
// Usage: message items arrive on the in channel (valid/ready, data_word,
// valid_bytes, message_end). Bytes are packed one per cycle into the block
// buffer, pausing while a full block is compressed. A full block runs the
// round unit in sha_core for 80 rounds, one round per cycle; ready is low
// throughout. The last item pads (one or two blocks, zero fill one byte per
// cycle) and then emits 6 or 8 digest words on the out channel, one per cycle
// while ready is high. A stalled receiver holds the current word; nothing
// else proceeds meanwhile.
// Reset loads the SHA-512 initial values, clears the byte count and the mode.
// A cfg_we write loads the initial values of the mode in cfg_wdata and restarts.
// Sixteen full eight-byte items fill one block.
// The wait from the last item to the first digest word depends on the fill
// position and whether padding needs a second block.
`default_nettype none
module sha512_sha384_hash_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);
	typedef enum logic [2:0] {IDLE, PACK, PAD, LEN, WAITC, EMIT} state_t;
	state_t      st_q;
	logic        mode_q;
	logic [63:0] blk_q [16];
	logic [63:0] cnt_lo_q, cnt_hi_q;
	logic [63:0] data_q;
	logic [3:0]  left_q;
	logic        last_q;
	logic        finish_q;  // the pending compression is the final one
	logic [6:0]  pad_q;
	logic [2:0]  oidx_q;
	logic [63:0] hash [8];
	logic        done;
	sha_pkg::ctl_t ctl;
	logic        start_q;
	logic [6:0]  pos;
	logic [2:0]  nlast;

	assign pos = cnt_lo_q[6:0];
	assign nlast = mode_q ? 3'd5 : 3'd7;
	assign ctl.start = start_q;
	assign ctl.busy = (st_q == WAITC);
	assign in_ch.ready = (st_q == IDLE) && !cfg_we;
	assign out_ch.valid = (st_q == EMIT);
	assign out_ch.digest_word = hash[oidx_q];
	assign out_ch.digest_last = (oidx_q == nlast);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .blk(blk_q),
		.iv_load(cfg_we || (st_q == EMIT && out_ch.ready && oidx_q == nlast)),
		.iv_mode(cfg_we ? cfg_wdata : mode_q), .hash(hash), .done(done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			mode_q <= 1'b0;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
			start_q <= 1'b0;
			oidx_q <= '0;
			left_q <= '0;
			last_q <= 1'b0;
			finish_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
				cnt_lo_q <= '0;
				cnt_hi_q <= '0;
				st_q <= IDLE;
			end else begin
				unique case (st_q)
					IDLE: begin
						if (in_ch.valid) begin
							data_q <= in_ch.data_word;
							left_q <= (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
							last_q <= in_ch.message_end;
							st_q <= PACK;
						end
					end
					PACK: begin
						if (left_q != 4'd0) begin
							blk_q[pos[6:3]][8*(7-pos[2:0]) +: 8] <= data_q[63:56];
							data_q <= {data_q[55:0], 8'h00};
							left_q <= left_q - 4'd1;
							{cnt_hi_q, cnt_lo_q} <= {cnt_hi_q, cnt_lo_q} + 128'd1;
							if (pos == 7'd127) begin
								start_q <= 1'b1;
								finish_q <= 1'b0;
								st_q <= WAITC;
							end
						end else if (last_q) begin
							blk_q[pos[6:3]][8*(7-pos[2:0]) +: 8] <= 8'h80;
							pad_q <= pos + 7'd1;
							if (pos == 7'd127) begin
								start_q <= 1'b1;
								finish_q <= 1'b0;
								st_q <= WAITC;
							end else if (pos < 7'd112) begin
								st_q <= LEN;
							end else begin
								st_q <= PAD;
							end
						end else begin
							st_q <= IDLE;
						end
					end
					PAD: begin
						// No room for the length: zero fill to the block end and run it.
						blk_q[pad_q[6:3]][8*(7-pad_q[2:0]) +: 8] <= 8'h00;
						pad_q <= pad_q + 7'd1;
						if (pad_q == 7'd127) begin
							start_q <= 1'b1;
							finish_q <= 1'b0;
							st_q <= WAITC;
						end
					end
					LEN: begin
						if (pad_q < 7'd112) begin
							blk_q[pad_q[6:3]][8*(7-pad_q[2:0]) +: 8] <= 8'h00;
							pad_q <= pad_q + 7'd1;
						end else begin
							blk_q[14] <= {cnt_hi_q[60:0], cnt_lo_q[63:61]};
							blk_q[15] <= {cnt_lo_q[60:0], 3'b000};
							start_q <= 1'b1;
							finish_q <= 1'b1;
							st_q <= WAITC;
						end
					end
					WAITC: begin
						if (done) begin
							// By the next cycle the core has added the working words in.
							if (finish_q) begin
								oidx_q <= '0;
								st_q <= EMIT;
							end else if (left_q != 4'd0 || !last_q || pos == 7'd0) begin
								st_q <= PACK;
							end else begin
								// The marker byte went into the previous block.
								pad_q <= 7'd0;
								st_q <= LEN;
							end
						end
					end
					EMIT: begin
						if (out_ch.ready) begin
							oidx_q <= oidx_q + 3'd1;
							if (oidx_q == nlast) begin
								cnt_lo_q <= '0;
								cnt_hi_q <= '0;
								st_q <= IDLE;
							end
						end
					end
					default: st_q <= IDLE;
				endcase
			end
		end
	end
endmodule
`default_nettype wire
